// ----- rtl/core/nsng_pkg.sv -----
package nsng_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int MAX_LEN_DEFAULT = 64;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_in;
   } req_type;

   typedef struct packed {
      logic                         found;
      logic signed [DATA_WIDTH-1:0] answer;
      logic                         last_out;
   } rsp_type;

endpackage

// ----- rtl/core/nsng_ram.sv -----
module nsng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/nsng_stack.sv -----
module nsng_stack #(
   parameter int MAX_LEN = nsng_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_lower,
   input  logic                                go,
   input  logic                                clear,
   input  logic signed [nsng_pkg::DATA_WIDTH-1:0] key,
   input  logic [$clog2(MAX_LEN)-1:0]          idx,
   output logic                                ready,
   output logic                                pop_valid,
   output logic [$clog2(MAX_LEN)-1:0]          pop_pos
);
   import nsng_pkg::*;

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int EW = DATA_WIDTH + IW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_CHECK
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 top_ff, top_in;
   logic signed [DATA_WIDTH-1:0]  key_ff, key_in;
   logic [IW-1:0]                 idx_ff, idx_in;

   logic                          wr_en, rd_en;
   logic [IW-1:0]                 wr_addr, rd_addr;
   logic [EW-1:0]                 wr_data, rd_data;
   logic signed [DATA_WIDTH-1:0]  t_val;
   logic [IW-1:0]                 t_idx;
   logic [CW-1:0]                 top_m1, top_m2;
   logic                          pop;

   // each entry holds the value alongside its position
   nsng_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign t_val  = rd_data[EW-1:IW];
   assign t_idx  = rd_data[IW-1:0];
   assign top_m1 = top_ff - CW'(1);
   assign top_m2 = top_ff - CW'(2);
   assign pop    = pop_lower ? (t_val < key_ff) : (t_val > key_ff);

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = top_ff[IW-1:0];
      wr_data   = {key_ff, idx_ff};
      rd_en     = 1'b0;
      rd_addr   = top_m1[IW-1:0];
      pop_valid = 1'b0;
      pop_pos   = t_idx;
      case (state_ff)
         ST_IDLE: begin
            if (clear) begin
               top_in = '0;
            end
            if (go) begin
               key_in   = key;
               idx_in   = idx;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (top_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               top_in   = CW'(1);
               state_in = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (pop) begin
               pop_valid = 1'b1;
               if (top_ff == CW'(1)) begin
                  // emptied: new item takes the bottom slot
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = top_m2[IW-1:0];
                  top_in  = top_m1;
               end
            end else begin
               wr_en    = 1'b1;
               top_in   = top_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
      end
      key_ff <= key_in;
      idx_ff <= idx_in;
   end

   assign ready = (state_ff == ST_IDLE);

endmodule

// ----- rtl/core/next_smaller_of_next_greater.sv -----
// channel   ports                        handshake
// input     req_item (req_type)          start & !busy
// result    rsp_item (rsp_type)          rsp_strobe, one cycle, no stall
//
// A stored item keeps busy high while both stacks settle; the slower stack
// sets busy. The next item can go in once busy is low. An item past
// MAX_LEN is dropped without touching the stacks.
// The item with last_in then drains the results in order, each through
// T_RD1, T_RD2 and T_EMIT (result index lookup, then next-smaller lookup,
// each one memory read).
// Reset empties both stacks and the count; no memory clearing pass.
// The result side cannot stall; busy stays high until the last result.
module next_smaller_of_next_greater #(
   parameter int MAX_LEN = nsng_pkg::MAX_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nsng_pkg::req_type req_item,
   output logic              rsp_strobe,
   output nsng_pkg::rsp_type rsp_item
);
   import nsng_pkg::*;

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      T_IDLE,
      T_LOAD,
      T_RD1,
      T_RD2,
      T_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         last_ff, last_in;
   logic [IW-1:0]                oi_ff, oi_in;
   logic                         none_ff, none_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   rsp_type                      rsp_item_ff, rsp_item_in;

   logic                         accept, init, stk_go, stk_clear;
   logic [IW-1:0]                idx;
   logic                         g_ready, s_ready, g_pop, s_pop;
   logic [IW-1:0]                g_pos, s_pos;

   logic                         gi_wr_en, gi_rd_en;
   logic [IW-1:0]                gi_wr_addr;
   logic [IW:0]                  gi_wr_data, gi_rd_data;
   logic                         sv_wr_en, sv_rd_en;
   logic [IW-1:0]                sv_wr_addr;
   logic [DATA_WIDTH:0]          sv_wr_data, sv_rd_data;
   logic                         found;

   assign accept    = start && (state_ff == T_IDLE);
   assign init      = accept && (count_ff < CW'(MAX_LEN));
   assign stk_go    = init;
   assign idx       = count_ff[IW-1:0];
   assign stk_clear = (state_ff == T_EMIT) && rsp_item_in.last_out;

   nsng_stack #(.MAX_LEN(MAX_LEN)) u_greater (
      .clock     (clock),
      .reset     (reset),
      .pop_lower (1'b1),
      .go        (stk_go),
      .clear     (stk_clear),
      .key       (req_item.value),
      .idx       (idx),
      .ready     (g_ready),
      .pop_valid (g_pop),
      .pop_pos   (g_pos)
   );

   nsng_stack #(.MAX_LEN(MAX_LEN)) u_smaller (
      .clock     (clock),
      .reset     (reset),
      .pop_lower (1'b0),
      .go        (stk_go),
      .clear     (stk_clear),
      .key       (req_item.value),
      .idx       (idx),
      .ready     (s_ready),
      .pop_valid (s_pop),
      .pop_pos   (s_pos)
   );

   // next-greater index per position: {none, index}
   assign gi_wr_en   = init || g_pop;
   assign gi_wr_addr = init ? idx : g_pos;
   assign gi_wr_data = init ? {1'b1, {IW{1'b0}}} : {1'b0, idx};
   assign gi_rd_en   = (state_ff == T_RD1);

   nsng_ram #(.WIDTH(IW + 1), .DEPTH(MAX_LEN)) u_greater_index (
      .clock   (clock),
      .wr_en   (gi_wr_en),
      .wr_addr (gi_wr_addr),
      .wr_data (gi_wr_data),
      .rd_en   (gi_rd_en),
      .rd_addr (oi_ff),
      .rd_data (gi_rd_data)
   );

   // next-smaller value per position: {valid, value}
   assign sv_wr_en   = init || s_pop;
   assign sv_wr_addr = init ? idx : s_pos;
   assign sv_wr_data = init ? {1'b0, {DATA_WIDTH{1'b0}}} : {1'b1, key_ff};
   assign sv_rd_en   = (state_ff == T_RD2);

   nsng_ram #(.WIDTH(DATA_WIDTH + 1), .DEPTH(MAX_LEN)) u_smaller_value (
      .clock   (clock),
      .wr_en   (sv_wr_en),
      .wr_addr (sv_wr_addr),
      .wr_data (sv_wr_data),
      .rd_en   (sv_rd_en),
      .rd_addr (gi_rd_data[IW-1:0]),
      .rd_data (sv_rd_data)
   );

   assign found = !none_ff && sv_rd_data[DATA_WIDTH];

   always_comb begin
      state_in             = state_ff;
      count_in             = count_ff;
      last_in              = last_ff;
      oi_in                = oi_ff;
      none_in              = none_ff;
      key_in               = key_ff;
      rsp_strobe_in        = 1'b0;
      rsp_item_in          = rsp_item_ff;
      rsp_item_in.found    = found;
      rsp_item_in.answer   = found ? signed'(sv_rd_data[DATA_WIDTH-1:0]) : '0;
      rsp_item_in.last_out = ((CW'(oi_ff) + CW'(1)) == count_ff);
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               last_in = req_item.last_in;
               key_in  = req_item.value;
               oi_in   = '0;
               if (init) begin
                  state_in = T_LOAD;
               end else if (req_item.last_in) begin
                  state_in = T_RD1;
               end
            end
            rsp_item_in = rsp_item_ff;
         end
         T_LOAD: begin
            if (g_ready && s_ready) begin
               count_in = count_ff + CW'(1);
               state_in = last_ff ? T_RD1 : T_IDLE;
            end
            rsp_item_in = rsp_item_ff;
         end
         T_RD1: begin
            state_in    = T_RD2;
            rsp_item_in = rsp_item_ff;
         end
         T_RD2: begin
            none_in     = gi_rd_data[IW];
            state_in    = T_EMIT;
            rsp_item_in = rsp_item_ff;
         end
         T_EMIT: begin
            rsp_strobe_in = 1'b1;
            oi_in         = oi_ff + IW'(1);
            if (rsp_item_in.last_out) begin
               count_in = '0;
               state_in = T_IDLE;
            end else begin
               state_in = T_RD1;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      last_ff     <= last_in;
      oi_ff       <= oi_in;
      none_ff     <= none_in;
      key_ff      <= key_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != T_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ----- sim/nsng_checker.sv -----
module nsng_checker
   import nsng_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      mismatches,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [DATA_WIDTH-1:0] held_value [MAX_LEN];
   int                           greater_pos [MAX_LEN];
   logic signed [DATA_WIDTH-1:0] smaller_after [MAX_LEN];
   bit                           smaller_seen [MAX_LEN];
   int                           rise_stack [MAX_LEN];
   int                           fall_stack [MAX_LEN];
   int                           rise_depth;
   int                           fall_depth;
   int                           stored;
   rsp_type                      expected_answers [$];

   task automatic report_mismatch(input string what, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatches++;
   endtask

   // both stacks resolve on strict compares; equal values stay stacked
   task automatic take_value(input req_type item);
      logic signed [DATA_WIDTH-1:0] v;
      rsp_type                      r;
      int                           t;
      v = item.value;
      if (stored < MAX_LEN) begin
         held_value[stored] = v;
         greater_pos[stored] = -1;
         smaller_seen[stored] = 1'b0;
         smaller_after[stored] = '0;
         while (rise_depth > 0 && held_value[rise_stack[rise_depth-1]] < v) begin
            greater_pos[rise_stack[rise_depth-1]] = stored;
            rise_depth--;
         end
         rise_stack[rise_depth] = stored;
         rise_depth++;
         while (fall_depth > 0 && held_value[fall_stack[fall_depth-1]] > v) begin
            smaller_after[fall_stack[fall_depth-1]] = v;
            smaller_seen[fall_stack[fall_depth-1]] = 1'b1;
            fall_depth--;
         end
         fall_stack[fall_depth] = stored;
         fall_depth++;
         stored++;
      end
      if (item.last_in) begin
         for (int i = 0; i < stored; i++) begin
            t = greater_pos[i];
            r = '0;
            if (t >= 0) begin
               if (smaller_seen[t]) begin
                  r.found = 1'b1;
                  r.answer = smaller_after[t];
               end
            end
            r.last_out = (i == stored - 1);
            expected_answers = {expected_answers, r};
         end
         stored = 0;
         rise_depth = 0;
         fall_depth = 0;
      end
   endtask

   task automatic check_answer(input rsp_type got);
      rsp_type want;
      if (expected_answers.size() == 0) begin
         report_mismatch("result with no item pending", 0, got.answer);
      end else begin
         want = expected_answers.pop_front();
         if (got.found !== want.found)
            report_mismatch("found", want.found, got.found);
         if (got.answer !== want.answer)
            report_mismatch("answer", want.answer, got.answer);
         if (got.last_out !== want.last_out)
            report_mismatch("last_out", want.last_out, got.last_out);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatches = 0;
         stored = 0;
         rise_depth = 0;
         fall_depth = 0;
         expected_answers.delete();
      end else begin
         if (rsp_strobe)
            check_answer(rsp_item);
         if (start && !busy)
            take_value(req_item);
      end
      pending = expected_answers.size();
   end

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import nsng_pkg::*;

   localparam int ITEM_COUNT = 430;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      mismatches;
   int      pending;
   int      sent;

   always #5 clock = ~clock;

   next_smaller_of_next_greater uut (
      .clock, .reset, .start, .busy, .req_item, .rsp_strobe, .rsp_item
   );

   nsng_checker watch (
      .clock, .reset, .start, .busy, .req_item, .rsp_strobe, .rsp_item,
      .mismatches, .pending
   );

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         2, 3, 4, 5: return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // idle gaps, except for a calm stretch in the middle of the run
   task automatic send_item(input logic signed [DATA_WIDTH-1:0] v, input logic l);
      while (!(sent >= 150 && sent < 260) && $urandom_range(99) < 24) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= '{value: v, last_in: l};
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic send_random_run(input int len);
      for (int i = 0; i < len; i++)
         send_item(pick_value(), i == len - 1);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
   endtask

   initial begin
      int len;
      int pick;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single item at the top of the range
      send_item(32'sh7fffffff, 1'b1);
      // extremes: answer is the most negative value
      send_item(32'sh80000000, 1'b0);
      send_item(32'sh7fffffff, 1'b0);
      send_item(32'sh80000000, 1'b1);
      // equal values resolve nothing
      send_item(5, 1'b0);
      send_item(5, 1'b0);
      send_item(5, 1'b1);
      // true answer of -1 is still found
      send_item(0, 1'b0);
      send_item(3, 1'b0);
      send_item(-1, 1'b1);
      // rising run: no next-smaller anywhere
      send_item(1, 1'b0);
      send_item(2, 1'b0);
      send_item(3, 1'b1);
      send_item(5, 1'b0);
      send_item(1, 1'b0);
      send_item(9, 1'b0);
      send_item(2, 1'b0);
      send_item(5, 1'b0);
      send_item(1, 1'b0);
      send_item(7, 1'b1);
      drain_results();

      // overlong run: items past the store are dropped, last one still ends it
      send_random_run(66);
      while (sent < ITEM_COUNT) begin
         pick = $urandom_range(99);
         if (pick < 60)
            len = $urandom_range(8, 1);
         else if (pick < 90)
            len = $urandom_range(30, 9);
         else if (pick < 97)
            len = $urandom_range(64, 31);
         else
            len = $urandom_range(72, 65);
         send_random_run(len);
         if ($urandom_range(5) == 0)
            drain_results();
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
